// File: rtl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// Shared constants, payload types and control codes of the reservation
// lottery scheduler.
// ----------------------------------------------------------------------------
package rls_pkg;

  localparam int NUM_SLOTS     = 64;
  localparam int TABLE_ENTRIES = 200;
  localparam int SHARE_CAP     = 200;
  localparam int PCT_MAX       = 100;
  localparam int NANO_LIMIT    = 1000;
  localparam int TIME_STEP     = 10;
  localparam int BID_SCALE     = 10;

  localparam logic [31:0] LCG_MUL    = 32'd8253729;
  localparam logic [31:0] LCG_ADD    = 32'd2396403;
  localparam logic [31:0] SEED_RESET = 32'd123456789;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int OWN_W   = $clog2(NUM_SLOTS + 1);
  localparam int TKT_W   = $clog2(TABLE_ENTRIES);
  localparam int POS_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int PCT_W   = 7;
  localparam int BID_W   = 16;
  localparam int SHARE_W = 8;
  localparam int NANO_W  = 20;
  localparam int CNT_W   = 32;
  localparam int DVD_W   = 32;
  localparam int DIV_W   =
    $clog2(((TABLE_ENTRIES > NANO_LIMIT) ? TABLE_ENTRIES : NANO_LIMIT) + 1);

  // reciprocals rounded up, exact over the dividend widths
  localparam int TKT_SH  = DVD_W + $clog2(TABLE_ENTRIES);
  localparam int NANO_SH = NANO_W + $clog2(NANO_LIMIT);
  localparam logic [DVD_W:0] TKT_RCP = (DVD_W + 1)'(
    ((64'd1 << TKT_SH) + 64'(TABLE_ENTRIES - 1)) / 64'(TABLE_ENTRIES));
  localparam logic [DVD_W:0] NANO_RCP = (DVD_W + 1)'(
    ((64'd1 << NANO_SH) + 64'(NANO_LIMIT - 1)) / 64'(NANO_LIMIT));

  localparam int PADDR_W = 3;
  localparam logic REG_LCG_SEED = 1'b0;

  typedef enum logic [2:0] {
    ACT_RESERVE  = 3'd0,
    ACT_BID      = 3'd1,
    ACT_RUNNABLE = 3'd2,
    ACT_EXIT     = 3'd3,
    ACT_TICK     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_PCT   = 2'd1,
    STS_NO_SHARES = 2'd2,
    STS_BAD_BID   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  slot;
    logic [15:0] amount;
    logic        runnable_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        granted;
    logic [5:0]  granted_slot;
    logic [7:0]  reserved_total;
    logic [31:0] granted_charge_micro;
  } out_item_t;

  typedef struct packed {
    logic             runnable;
    logic [PCT_W-1:0] pct;
    logic [BID_W-1:0] bid;
  } slot_ent_t;

  typedef struct packed {
    logic [CNT_W-1:0]  chosen;
    logic [CNT_W-1:0]  elapsed;
    logic [NANO_W-1:0] nano;
    logic [CNT_W-1:0]  micro;
  } cnt_ent_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EXEC,
    OP_RB_RD,
    OP_RB_LOAD,
    OP_RB_WR,
    OP_RB_NEXT,
    OP_RB_ZERO,
    OP_LCG,
    OP_MOD_START,
    OP_TICKET_RD,
    OP_OWNER_RD,
    OP_RR_INIT,
    OP_RR_RD,
    OP_RR_NEXT,
    OP_GRANT_TKT,
    OP_GRANT_RR,
    OP_CHARGE,
    OP_DIVQ_START,
    OP_CNT_WR,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RB_RD,
    ST_RB_LOAD,
    ST_RB_WR,
    ST_RB_ZERO,
    ST_LCG,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_OWN,
    ST_OWN_CHK,
    ST_RR_RD,
    ST_RR_CHK,
    ST_CH_ADD,
    ST_CH_DEC,
    ST_CH_DIV,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    logic exec_rb;
    logic div_busy;
    logic share_nz;
    logic owner_nz;
    logic run;
    logic rr_last;
    logic rb_last;
    logic k_done;
    logic pos_full;
    logic need_div;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/rls_div.sv
// ----------------------------------------------------------------------------
// rls_div
// Constant divider by reciprocal multiplication, shared by the
// ticket draw and the charge conversion.
// ----------------------------------------------------------------------------
module rls_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      tkt_sel_i,
  input  logic [rls_pkg::DVD_W-1:0] dividend_i,
  output logic                      busy_o,
  output logic [rls_pkg::DVD_W-1:0] quo_o,
  output logic [rls_pkg::DIV_W-1:0] rem_o
);
  import rls_pkg::*;

  logic             busy_q;
  logic             stage_q;
  logic             sel_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W:0]   rcp;
  logic [2*DVD_W:0] prod_d;
  logic [2*DVD_W:0] prod_q;
  logic [DVD_W-1:0] quo_d;
  logic [DVD_W-1:0] quo_q;
  logic [DIV_W-1:0] rem_d;
  logic [DIV_W-1:0] rem_q;

  always_comb begin
    rcp    = sel_q ? TKT_RCP : NANO_RCP;
    prod_d = dvd_q * rcp;
    quo_d  = sel_q ? DVD_W'(prod_q >> TKT_SH) : DVD_W'(prod_q >> NANO_SH);
    rem_d  = sel_q ? DIV_W'(dvd_q - DVD_W'(quo_d * DVD_W'(TABLE_ENTRIES)))
                   : DIV_W'(dvd_q - DVD_W'(quo_d * DVD_W'(NANO_LIMIT)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      stage_q <= 1'b0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      stage_q <= 1'b0;
    end else if (busy_q) begin
      if (stage_q) begin
        busy_q <= 1'b0;
      end else begin
        stage_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      sel_q <= tkt_sel_i;
    end else if (busy_q && !stage_q) begin
      prod_q <= prod_d;
    end else if (busy_q && stage_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/rls_dpath.sv
// ----------------------------------------------------------------------------
// rls_dpath
// Slot, counter and ticket memories, share and generator registers, the
// divider and the result register.
// ----------------------------------------------------------------------------
module rls_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rls_pkg::in_item_t  in_i,
  input  rls_pkg::dp_op_e    op_i,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic [31:0]        seed_o,
  output rls_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rls_pkg::out_item_t out_o
);
  import rls_pkg::*;

  in_item_t item_q;

  slot_ent_t              slot_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   slot_vld_q;
  slot_ent_t              slot_rd_q;
  logic                   slot_rd_vld_q;
  slot_ent_t              slot_eff;
  logic                   slot_re;
  logic [SLOT_W-1:0]      slot_raddr;
  logic                   slot_we;
  slot_ent_t              slot_wdata;

  cnt_ent_t               cnt_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   cnt_vld_q;
  cnt_ent_t               cnt_rd_q;
  logic                   cnt_rd_vld_q;
  cnt_ent_t               cnt_eff;
  cnt_ent_t               cnt_wdata;
  logic                   cnt_re;
  logic                   cnt_we;

  logic [OWN_W-1:0]       tkt_mem [TABLE_ENTRIES];
  logic [OWN_W-1:0]       tkt_rd_q;
  logic                   tkt_we;
  logic [OWN_W-1:0]       tkt_wdata;

  logic [31:0]            seed_q;
  logic [31:0]            gen_q;
  logic [SHARE_W-1:0]     share_q;
  logic [SHARE_W-1:0]     share_d;
  logic [SLOT_W-1:0]      rr_q;
  logic [SLOT_W-1:0]      cur_q;
  logic [SLOT_W-1:0]      cur_inc;
  logic [SLOT_W-1:0]      scan_q;
  logic [SLOT_W-1:0]      rb_slot_q;
  logic [POS_W-1:0]       pos_q;
  logic [PCT_W-1:0]       k_q;
  logic [PCT_W-1:0]       rb_pct_q;

  status_e                status_q;
  status_e                status_d;
  logic                   granted_q;
  logic [5:0]             gslot_q;
  logic [CNT_W-1:0]       gmicro_q;
  logic [NANO_W-1:0]      nano_sum_q;
  logic [NANO_W-1:0]      nano_inc;
  logic                   need_div;

  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   slot_ok;
  logic [SHARE_W-1:0]     freed;
  logic                   pct_ok;
  logic                   fits;
  logic                   exec_wr;
  logic                   exec_rb;

  logic                   div_start;
  logic                   div_sel;
  logic [DVD_W-1:0]       div_dvd;
  logic                   div_busy;
  logic [DVD_W-1:0]       div_quo;
  logic [DIV_W-1:0]       div_rem;

  rls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .tkt_sel_i  (div_sel),
    .dividend_i (div_dvd),
    .busy_o     (div_busy),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  assign slot_eff = slot_rd_vld_q ? slot_rd_q : '0;
  assign cnt_eff  = cnt_rd_vld_q ? cnt_rd_q : '0;
  assign cur_inc  = (cur_q == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_q + 1'b1;

  // action decode for reserve, bid, runnable and exit
  always_comb begin
    slot_ok    = int'(item_q.slot) < NUM_SLOTS;
    freed      = share_q - SHARE_W'(slot_eff.pct);
    pct_ok     = (item_q.amount >= 16'd1) && (item_q.amount <= 16'(PCT_MAX));
    fits       = (17'(freed) + 17'(item_q.amount)) <= 17'(SHARE_CAP);
    exec_wr    = 1'b0;
    exec_rb    = 1'b0;
    status_d   = STS_OK;
    share_d    = share_q;
    slot_wdata = slot_eff;
    if (slot_ok) begin
      case (action_e'(item_q.action))
        ACT_RESERVE: begin
          if (!pct_ok) begin
            status_d = STS_BAD_PCT;
          end else if (!fits) begin
            status_d = STS_NO_SHARES;
          end else begin
            exec_wr    = 1'b1;
            exec_rb    = 1'b1;
            share_d    = freed + SHARE_W'(item_q.amount);
            slot_wdata = '{runnable: slot_eff.runnable,
                           pct: PCT_W'(item_q.amount), bid: '0};
          end
        end
        ACT_BID: begin
          if (item_q.amount == '0) begin
            status_d = STS_BAD_BID;
          end else begin
            exec_wr    = 1'b1;
            exec_rb    = 1'b1;
            share_d    = freed;
            slot_wdata = '{runnable: slot_eff.runnable, pct: '0,
                           bid: item_q.amount};
          end
        end
        ACT_RUNNABLE: begin
          exec_wr    = 1'b1;
          slot_wdata = '{runnable: item_q.runnable_flag, pct: slot_eff.pct,
                         bid: slot_eff.bid};
        end
        ACT_EXIT: begin
          exec_wr    = 1'b1;
          exec_rb    = 1'b1;
          share_d    = freed;
          slot_wdata = '0;
        end
        default: begin
          exec_wr = 1'b0;
        end
      endcase
    end
  end

  // slot memory port select
  always_comb begin
    slot_re    = 1'b1;
    slot_raddr = cur_q;
    case (op_i)
      OP_ACCEPT:   slot_raddr = SLOT_W'(in_i.slot);
      OP_OWNER_RD: slot_raddr = SLOT_W'(tkt_rd_q - OWN_W'(1));
      OP_RR_RD:    slot_raddr = cur_q;
      OP_RB_RD:    slot_raddr = rb_slot_q;
      default:     slot_re    = 1'b0;
    endcase
    slot_we = (op_i == OP_EXEC) && exec_wr;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[SLOT_W'(item_q.slot)] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q    <= '0;
      slot_rd_vld_q <= 1'b0;
    end else begin
      if (slot_we) begin
        slot_vld_q[SLOT_W'(item_q.slot)] <= 1'b1;
      end
      if (slot_re) begin
        slot_rd_vld_q <= slot_vld_q[slot_raddr];
      end
    end
  end

  // charge update
  always_comb begin
    nano_inc  = (slot_eff.pct != '0) ? NANO_W'(NANO_LIMIT)
                                     : NANO_W'(slot_eff.bid) * NANO_W'(BID_SCALE);
    need_div  = nano_sum_q > NANO_W'(NANO_LIMIT);
    cnt_re    = (op_i == OP_GRANT_TKT) || (op_i == OP_GRANT_RR);
    cnt_we    = op_i == OP_CNT_WR;
    cnt_wdata = '{chosen:  cnt_eff.chosen + CNT_W'(1),
                  elapsed: cnt_eff.elapsed + CNT_W'(TIME_STEP),
                  nano:    need_div ? '0 : nano_sum_q,
                  micro:   cnt_eff.micro + (need_div ? CNT_W'(div_quo) : '0)};
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cur_q] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[cur_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q    <= '0;
      cnt_rd_vld_q <= 1'b0;
    end else begin
      if (cnt_we) begin
        cnt_vld_q[cur_q] <= 1'b1;
      end
      if (cnt_re) begin
        cnt_rd_vld_q <= cnt_vld_q[cur_q];
      end
    end
  end

  // ticket table, fully rewritten on every rebuild
  assign tkt_we    = (op_i == OP_RB_WR) || (op_i == OP_RB_ZERO);
  assign tkt_wdata = (op_i == OP_RB_WR) ? OWN_W'(rb_slot_q) + OWN_W'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (tkt_we) begin
      tkt_mem[pos_q[TKT_W-1:0]] <= tkt_wdata;
    end
    if (op_i == OP_TICKET_RD) begin
      tkt_rd_q <= tkt_mem[div_rem[TKT_W-1:0]];
    end
  end

  // shared divider
  always_comb begin
    div_start = (op_i == OP_MOD_START) || (op_i == OP_DIVQ_START);
    div_sel   = op_i == OP_MOD_START;
    if (op_i == OP_MOD_START) begin
      div_dvd = gen_q[31] ? (~gen_q + 32'd1) : gen_q;
    end else begin
      div_dvd = DVD_W'(nano_sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SEED_RESET;
      gen_q       <= SEED_RESET;
      share_q     <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
        gen_q  <= cfg_wdata_i;
      end else if (op_i == OP_LCG) begin
        gen_q <= gen_q * LCG_MUL + LCG_ADD;
      end
      if (op_i == OP_EXEC) begin
        share_q <= share_d;
      end
      if (op_i == OP_GRANT_RR) begin
        rr_q <= cur_inc;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (op_i == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_ACCEPT: begin
        item_q    <= in_i;
        status_q  <= STS_OK;
        granted_q <= 1'b0;
        gslot_q   <= '0;
        gmicro_q  <= '0;
      end
      OP_EXEC: begin
        status_q  <= status_d;
        rb_slot_q <= '0;
        pos_q     <= '0;
      end
      OP_RB_LOAD: begin
        k_q      <= '0;
        rb_pct_q <= slot_eff.pct;
      end
      OP_RB_WR: begin
        k_q   <= k_q + 1'b1;
        pos_q <= pos_q + 1'b1;
      end
      OP_RB_NEXT: rb_slot_q <= rb_slot_q + 1'b1;
      OP_RB_ZERO: pos_q     <= pos_q + 1'b1;
      OP_OWNER_RD: cur_q    <= SLOT_W'(tkt_rd_q - OWN_W'(1));
      OP_RR_INIT: begin
        cur_q  <= rr_q;
        scan_q <= '0;
      end
      OP_RR_NEXT: begin
        cur_q  <= cur_inc;
        scan_q <= scan_q + 1'b1;
      end
      OP_GRANT_TKT, OP_GRANT_RR: begin
        granted_q <= 1'b1;
        gslot_q   <= 6'(cur_q);
      end
      OP_CHARGE: nano_sum_q <= cnt_eff.nano + nano_inc;
      OP_CNT_WR: gmicro_q   <= cnt_wdata.micro;
      OP_FINISH: begin
        out_q <= '{status: status_q, granted: granted_q, granted_slot: gslot_q,
                   reserved_total: share_q, granted_charge_micro: gmicro_q};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts_o.exec_rb  = exec_rb;
    sts_o.div_busy = div_busy;
    sts_o.share_nz = share_q != '0;
    sts_o.owner_nz = tkt_rd_q != '0;
    sts_o.run      = slot_eff.runnable;
    sts_o.rr_last  = scan_q == SLOT_W'(NUM_SLOTS - 1);
    sts_o.rb_last  = rb_slot_q == SLOT_W'(NUM_SLOTS - 1);
    sts_o.pos_full = pos_q >= POS_W'(TABLE_ENTRIES);
    sts_o.k_done   = (k_q >= rb_pct_q) || sts_o.pos_full;
    sts_o.need_div = need_div;
    sts_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign seed_o      = seed_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/rls_ctrl.sv
// ----------------------------------------------------------------------------
// rls_ctrl
// Sequencer of the scheduler: request decode, table rebuild, ticket draw,
// round-robin scan and charge update.
// ----------------------------------------------------------------------------
module rls_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_tick_i,
  input  rls_pkg::dp_sts_t sts_i,
  output rls_pkg::dp_op_e  op_o,
  output logic             in_stall_o
);
  import rls_pkg::*;

  ctrl_state_e state_q;
  ctrl_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = in_tick_i ? ST_LCG : ST_EXEC;
      ST_EXEC:     state_d = sts_i.exec_rb ? ST_RB_RD : ST_FIN;
      ST_RB_RD:    state_d = ST_RB_LOAD;
      ST_RB_LOAD:  state_d = ST_RB_WR;
      ST_RB_WR: begin
        if (sts_i.k_done) state_d = sts_i.rb_last ? ST_RB_ZERO : ST_RB_RD;
      end
      ST_RB_ZERO:  if (sts_i.pos_full) state_d = ST_FIN;
      ST_LCG:      state_d = ST_MOD_GO;
      ST_MOD_GO:   state_d = ST_MOD_WAIT;
      ST_MOD_WAIT: begin
        if (!sts_i.div_busy) state_d = sts_i.share_nz ? ST_OWN : ST_RR_RD;
      end
      ST_OWN:      state_d = sts_i.owner_nz ? ST_OWN_CHK : ST_RR_RD;
      ST_OWN_CHK:  state_d = sts_i.run ? ST_CH_ADD : ST_FIN;
      ST_RR_RD:    state_d = ST_RR_CHK;
      ST_RR_CHK: begin
        if (sts_i.run) begin
          state_d = ST_CH_ADD;
        end else begin
          state_d = sts_i.rr_last ? ST_FIN : ST_RR_RD;
        end
      end
      ST_CH_ADD:   state_d = ST_CH_DEC;
      ST_CH_DEC:   state_d = sts_i.need_div ? ST_CH_DIV : ST_FIN;
      ST_CH_DIV:   if (!sts_i.div_busy) state_d = ST_FIN;
      ST_FIN:      if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_stall_o = state_q != ST_IDLE;
    case (state_q)
      ST_IDLE:     if (in_valid_i) op_o = OP_ACCEPT;
      ST_EXEC:     op_o = OP_EXEC;
      ST_RB_RD:    op_o = OP_RB_RD;
      ST_RB_LOAD:  op_o = OP_RB_LOAD;
      ST_RB_WR: begin
        if (!sts_i.k_done) begin
          op_o = OP_RB_WR;
        end else if (!sts_i.rb_last) begin
          op_o = OP_RB_NEXT;
        end
      end
      ST_RB_ZERO:  if (!sts_i.pos_full) op_o = OP_RB_ZERO;
      ST_LCG:      op_o = OP_LCG;
      ST_MOD_GO:   op_o = OP_MOD_START;
      ST_MOD_WAIT: begin
        if (!sts_i.div_busy) op_o = sts_i.share_nz ? OP_TICKET_RD : OP_RR_INIT;
      end
      ST_OWN:      op_o = sts_i.owner_nz ? OP_OWNER_RD : OP_RR_INIT;
      ST_OWN_CHK:  if (sts_i.run) op_o = OP_GRANT_TKT;
      ST_RR_RD:    op_o = OP_RR_RD;
      ST_RR_CHK: begin
        if (sts_i.run) begin
          op_o = OP_GRANT_RR;
        end else if (!sts_i.rr_last) begin
          op_o = OP_RR_NEXT;
        end
      end
      ST_CH_ADD:   op_o = OP_CHARGE;
      ST_CH_DEC:   op_o = sts_i.need_div ? OP_DIVQ_START : OP_CNT_WR;
      ST_CH_DIV:   if (!sts_i.div_busy) op_o = OP_CNT_WR;
      ST_FIN:      if (sts_i.out_free) op_o = OP_FINISH;
      default:     op_o = OP_NONE;
    endcase
  end

endmodule

// File: rtl/reservation_lottery_scheduler.sv
// ----------------------------------------------------------------------------
// reservation_lottery_scheduler
// Lottery arbiter with share reservations: one result beat per request beat.
// Runnable flag, rejected and unknown requests go straight from decode to the
//   result; accepted reserve, bid and exit first rebuild the ticket table.
// Tick: ticket draw, or round-robin scan when no shares or no ticket owner.
// One request at a time; the next is taken the cycle after its result is loaded.
// Reset: asynchronous, control and valid state cleared at once, no clearing pass.
// ----------------------------------------------------------------------------
module reservation_lottery_scheduler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rls_pkg::in_item_t                in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rls_pkg::out_item_t               out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rls_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rls_pkg::*;

  dp_op_e      op;
  dp_sts_t     sts;
  logic        cfg_we;
  logic        in_tick;
  logic [31:0] seed;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && (paddr[2] == REG_LCG_SEED);
  assign prdata  = (paddr[2] == REG_LCG_SEED) ? seed : '0;
  assign in_tick = in_i.action == ACT_TICK;

  rls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_tick_i  (in_tick),
    .sts_i      (sts),
    .op_o       (op),
    .in_stall_o (in_stall_o)
  );

  rls_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .op_i        (op),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata),
    .seed_o      (seed),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while another is in flight");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.granted) |-> (out_o.status == STS_OK))
    else $error("grant with error status");

  a_no_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.granted) |->
      (out_o.granted_slot == '0 && out_o.granted_charge_micro == '0))
    else $error("grant fields set without grant");

  a_share_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.reserved_total <= 8'(SHARE_CAP)))
    else $error("reserved shares above cap");

endmodule
